@@ hw/rtl/csef_pkg.sv @@
// ----------------------------------------------------------------------------
// csef_pkg: shared types, constants and arithmetic for the compass edge filter
// Line store geometry, register indexes, queue entry types, compass kernel
// table and the per-channel arithmetic used by the back end.
// ----------------------------------------------------------------------------
`default_nettype none

package csef_pkg;

  // Line store geometry
  localparam int LINE_MAX = 2048;
  localparam int LINE_AW  = $clog2(LINE_MAX);

  // Field widths
  localparam int PIX_W   = 24;
  localparam int CHAN_W  = 8;
  localparam int WIDTH_W = 12;
  localparam int ROW_W   = 16;
  localparam int RESP_W  = 12;

  // Configuration port
  localparam int CFG_IDX_W  = 1;
  localparam int CFG_DATA_W = 16;
  localparam logic [CFG_IDX_W-1:0] REG_FRAME_WIDTH  = 1'd0;
  localparam logic [CFG_IDX_W-1:0] REG_FRAME_HEIGHT = 1'd1;
  localparam logic [WIDTH_W-1:0]   WIDTH_RESET  = 12'd640;
  localparam logic [ROW_W-1:0]     HEIGHT_RESET = 16'd480;
  localparam logic [WIDTH_W-1:0]   WIDTH_MIN    = 12'd3;
  localparam logic [ROW_W-1:0]     HEIGHT_MIN   = 16'd3;

  // Queue depths
  localparam int WQ_DEPTH  = 4;
  localparam int WQ_AW     = $clog2(WQ_DEPTH);
  localparam int OUT_DEPTH = 4;
  localparam int OUT_AW    = $clog2(OUT_DEPTH);

  // Arithmetic constants: q = s/8 + 15, v = floor(9q/5), clamp to 255
  localparam logic [7:0]  Q_OFFSET  = 8'd15;
  localparam logic [22:0] RECIP_5   = 23'd3277;  // 2^14/5 rounded up
  localparam int          RECIP_SH  = 14;
  localparam logic [8:0]  BYTE_MAX  = 9'd255;

  // 3x3 window, index = row*3 + col, pixel packed {red, green, blue}
  typedef logic [8:0][PIX_W-1:0]  win_px_t;
  typedef logic [8:0][CHAN_W-1:0] win_ch_t;

  // Front to back transaction
  typedef struct packed {
    win_px_t px;
    logic    zero;   // border center: all channels forced to 0
    logic    last;   // final result of the frame
  } csef_win_t;

  // Output queue entry
  typedef struct packed {
    logic [CHAN_W-1:0] red;
    logic [CHAN_W-1:0] green;
    logic [CHAN_W-1:0] blue;
    logic              last;
  } csef_out_t;

  // Four base compass kernels; the other four are their negations
  localparam logic signed [2:0] KERNEL [4][9] = '{
    '{-3'sd1,  3'sd0,  3'sd1, -3'sd2,  3'sd0,  3'sd2, -3'sd1,  3'sd0,  3'sd1},
    '{ 3'sd0,  3'sd1,  3'sd2, -3'sd1,  3'sd0,  3'sd1, -3'sd2, -3'sd1,  3'sd0},
    '{ 3'sd1,  3'sd2,  3'sd1,  3'sd0,  3'sd0,  3'sd0, -3'sd1, -3'sd2, -3'sd1},
    '{ 3'sd2,  3'sd1,  3'sd0,  3'sd1,  3'sd0, -3'sd1,  3'sd0, -3'sd1, -3'sd2}
  };

  // Pull one channel out of the window (0 red, 1 green, 2 blue)
  function automatic win_ch_t get_chan(input win_px_t px, input int ch);
    win_ch_t r;
    for (int i = 0; i < 9; i++) begin
      r[i] = px[i][(2-ch)*CHAN_W +: CHAN_W];
    end
    return r;
  endfunction

  // Response of one base kernel over one channel
  function automatic logic signed [RESP_W-1:0] kernel_resp(input win_ch_t p, input int k);
    logic signed [RESP_W-1:0] acc;
    acc = '0;
    for (int i = 0; i < 9; i++) begin
      acc = acc + RESP_W'(KERNEL[k][i] * $signed({4'b0, p[i]}));
    end
    return acc;
  endfunction

  // clamp(acc) + clamp(-acc) == min(|acc|, 255)
  function automatic logic [CHAN_W-1:0] resp_mag(input logic signed [RESP_W-1:0] acc);
    logic [RESP_W-1:0] a;
    a = acc[RESP_W-1] ? RESP_W'(-acc) : RESP_W'(acc);
    return (a > RESP_W'(BYTE_MAX)) ? CHAN_W'(BYTE_MAX) : a[CHAN_W-1:0];
  endfunction

  // floor(9q/5) clamped to 255; reciprocal multiply is exact for 9q <= 2047
  function automatic logic [CHAN_W-1:0] scale_out(input logic [7:0] q);
    logic [10:0] x;
    logic [22:0] prod;
    logic [8:0]  v;
    x    = {q, 3'b000} + 11'(q);
    prod = {12'b0, x} * RECIP_5;
    v    = prod[RECIP_SH +: 9];
    return (v > BYTE_MAX) ? CHAN_W'(BYTE_MAX) : v[CHAN_W-1:0];
  endfunction

endpackage

`default_nettype wire

@@ hw/rtl/compass_sobel_edge_filter.sv @@
// ----------------------------------------------------------------------------
// compass_sobel_edge_filter: 3x3 compass Sobel edge filter on an RGB stream
// Pixels enter in raster order through a queue-style port (push/full) and
// filtered window centers leave through a second queue-style port
// (empty/pop). frame_width and frame_height are written through the cfg
// channel (index 0 width, index 1 height); the user must write them only
// while the block is idle, which the block does not enforce. cfg_ready is
// always high. Width saturates to 3..2048, height below 3 is taken as 3. A
// pixel at row r >= 1, column c >= 1 yields the result for center (r-1,
// c-1); centers on the first row or column give zero, centers on the last
// row or column are not produced. frame_last marks the frame's final result.
// Throughput is one pixel per cycle while full is low: the line store does
// one read and one write per pixel on separate ports, and the kernel
// pipeline takes one window per cycle while it has credit. A result passes
// the line store read and stage 1, the window queue, the kernel responses,
// the magnitude sum and the output queue in that order. Reset clears the
// position counters, window, queues and loads the default geometry (640 x
// 480); the line store is not cleared. When the receiver stops popping, the
// output and window queues fill and full rises; no result is lost.
// ----------------------------------------------------------------------------
`default_nettype none

module compass_sobel_edge_filter import csef_pkg::*; (
  input  wire logic                  clk,
  input  wire logic                  rst,
  // configuration
  input  wire logic                  cfg_valid,
  output logic                       cfg_ready,
  input  wire logic [CFG_IDX_W-1:0]  cfg_index,
  input  wire logic [CFG_DATA_W-1:0] cfg_data,
  // pixel input
  input  wire logic                  push,
  output logic                       full,
  input  wire logic [CHAN_W-1:0]     in_red,
  input  wire logic [CHAN_W-1:0]     in_green,
  input  wire logic [CHAN_W-1:0]     in_blue,
  // result output
  output logic                       empty,
  input  wire logic                  pop,
  output logic [CHAN_W-1:0]          out_red,
  output logic [CHAN_W-1:0]          out_green,
  output logic [CHAN_W-1:0]          out_blue,
  output logic                       frame_last
);

  logic      wq_push;
  logic      wq_full;
  logic      wq_pop;
  logic      wq_empty;
  csef_win_t wq_in;
  csef_win_t wq_out;

  // Intake, line store and window
  csef_front u_front (
    .clk       (clk),
    .rst       (rst),
    .cfg_valid (cfg_valid),
    .cfg_ready (cfg_ready),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data),
    .push      (push),
    .full      (full),
    .in_red    (in_red),
    .in_green  (in_green),
    .in_blue   (in_blue),
    .q_push    (wq_push),
    .q_entry   (wq_in),
    .q_full    (wq_full)
  );

  // Decoupling queue
  csef_win_queue u_queue (
    .clk       (clk),
    .rst       (rst),
    .push      (wq_push),
    .entry_in  (wq_in),
    .full      (wq_full),
    .pop       (wq_pop),
    .entry_out (wq_out),
    .empty     (wq_empty)
  );

  // Filter pipeline and result queue
  csef_back u_back (
    .clk        (clk),
    .rst        (rst),
    .q_empty    (wq_empty),
    .q_entry    (wq_out),
    .q_pop      (wq_pop),
    .empty      (empty),
    .pop        (pop),
    .out_red    (out_red),
    .out_green  (out_green),
    .out_blue   (out_blue),
    .frame_last (frame_last)
  );

endmodule

`default_nettype wire

@@ hw/rtl/csef_front.sv @@
// ----------------------------------------------------------------------------
// csef_front: pixel intake, position tracking, line store and window
// Accepts one pixel per cycle while full is low, looks up the two previous
// rows, shifts the 3x3 window and classifies the center for the queue.
// ----------------------------------------------------------------------------
`default_nettype none

module csef_front import csef_pkg::*; (
  input  wire logic                  clk,
  input  wire logic                  rst,
  // configuration
  input  wire logic                  cfg_valid,
  output logic                       cfg_ready,
  input  wire logic [CFG_IDX_W-1:0]  cfg_index,
  input  wire logic [CFG_DATA_W-1:0] cfg_data,
  // pixel intake
  input  wire logic                  push,
  output logic                       full,
  input  wire logic [CHAN_W-1:0]     in_red,
  input  wire logic [CHAN_W-1:0]     in_green,
  input  wire logic [CHAN_W-1:0]     in_blue,
  // window queue
  output logic                       q_push,
  output csef_win_t                  q_entry,
  input  wire logic                  q_full
);

  logic [WIDTH_W-1:0] frame_width;
  logic [ROW_W-1:0]   frame_height;
  logic [WIDTH_W-1:0] w_eff;
  logic [ROW_W-1:0]   h_eff;

  logic [LINE_AW-1:0] column_count;
  logic [ROW_W-1:0]   row_count;
  logic [LINE_AW-1:0] col_cur;
  logic [ROW_W-1:0]   row_cur;
  logic [LINE_AW-1:0] column_count_next;
  logic [ROW_W-1:0]   row_count_next;

  logic               accept;
  logic               advance;

  logic               s1_valid;
  logic [PIX_W-1:0]   s1_pix;
  logic [LINE_AW-1:0] s1_col;
  logic               s1_emit;
  logic               s1_zero;
  logic               s1_last;

  logic [PIX_W-1:0]   mid_mem [LINE_MAX];
  logic [PIX_W-1:0]   top_mem [LINE_MAX];
  logic [PIX_W-1:0]   mid_rd;
  logic [PIX_W-1:0]   top_rd;
  logic [PIX_W-1:0]   window_regs [6];

  // Configuration registers, always ready
  assign cfg_ready = 1'b1;

  always_ff @(posedge clk) begin
    if (rst) begin
      frame_width  <= WIDTH_RESET;
      frame_height <= HEIGHT_RESET;
    end else if (cfg_valid) begin
      unique case (cfg_index)
        REG_FRAME_WIDTH:  frame_width  <= cfg_data[WIDTH_W-1:0];
        REG_FRAME_HEIGHT: frame_height <= cfg_data;
        default: ;
      endcase
    end
  end

  // Saturated frame geometry
  always_comb begin
    if (frame_width < WIDTH_MIN) begin
      w_eff = WIDTH_MIN;
    end else if (frame_width > WIDTH_W'(LINE_MAX)) begin
      w_eff = WIDTH_W'(LINE_MAX);
    end else begin
      w_eff = frame_width;
    end
    h_eff = (frame_height < HEIGHT_MIN) ? HEIGHT_MIN : frame_height;
  end

  // Position of the incoming pixel and of the one after it
  always_comb begin
    logic [ROW_W:0]   r_tmp;
    logic [WIDTH_W:0] c_plus;
    logic [ROW_W:0]   r_plus;
    if ({1'b0, column_count} >= w_eff) begin
      col_cur = '0;
      r_tmp   = {1'b0, row_count} + (ROW_W+1)'(1);
    end else begin
      col_cur = column_count;
      r_tmp   = {1'b0, row_count};
    end
    row_cur = (r_tmp >= {1'b0, h_eff}) ? '0 : r_tmp[ROW_W-1:0];

    c_plus = {2'b0, col_cur} + (WIDTH_W+1)'(1);
    r_plus = {1'b0, row_cur} + (ROW_W+1)'(1);
    if (c_plus >= {1'b0, w_eff}) begin
      column_count_next = '0;
      row_count_next    = (r_plus >= {1'b0, h_eff}) ? '0 : r_plus[ROW_W-1:0];
    end else begin
      column_count_next = c_plus[LINE_AW-1:0];
      row_count_next    = row_cur;
    end
  end

  // Handshake: stage 1 leaves when its center needs no slot or the queue has one
  assign advance = s1_valid && (!s1_emit || !q_full);
  assign full    = s1_valid && !advance;
  assign accept  = push && !full;

  always_ff @(posedge clk) begin
    if (rst) begin
      column_count <= '0;
      row_count    <= '0;
    end else if (accept) begin
      column_count <= column_count_next;
      row_count    <= row_count_next;
    end
  end

  // Stage 1 control
  always_ff @(posedge clk) begin
    if (rst) begin
      s1_valid <= 1'b0;
    end else if (accept) begin
      s1_valid <= 1'b1;
    end else if (advance) begin
      s1_valid <= 1'b0;
    end
  end

  // Stage 1 payload and classification
  always_ff @(posedge clk) begin
    if (accept) begin
      s1_pix  <= {in_red, in_green, in_blue};
      s1_col  <= col_cur;
      s1_emit <= (row_cur != '0) && (col_cur != '0);
      s1_zero <= (row_cur == ROW_W'(1)) || (col_cur == LINE_AW'(1));
      s1_last <= (row_cur == h_eff - ROW_W'(1)) &&
                 ({1'b0, col_cur} == w_eff - WIDTH_W'(1));
    end
  end

  // Line stores: read on accept, write back as the pixel leaves stage 1
  always_ff @(posedge clk) begin
    if (accept) begin
      mid_rd <= mid_mem[col_cur];
    end
    if (advance) begin
      mid_mem[s1_col] <= s1_pix;
    end
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      top_rd <= top_mem[col_cur];
    end
    if (advance) begin
      top_mem[s1_col] <= mid_rd;
    end
  end

  // Window columns: oldest in 0..2, middle in 3..5
  always_ff @(posedge clk) begin
    if (rst) begin
      for (int i = 0; i < 6; i++) begin
        window_regs[i] <= '0;
      end
    end else if (advance) begin
      window_regs[0] <= window_regs[3];
      window_regs[1] <= window_regs[4];
      window_regs[2] <= window_regs[5];
      window_regs[3] <= top_rd;
      window_regs[4] <= mid_rd;
      window_regs[5] <= s1_pix;
    end
  end

  // Queue transaction
  assign q_push = advance && s1_emit;

  always_comb begin
    q_entry.px[0] = window_regs[0];
    q_entry.px[1] = window_regs[3];
    q_entry.px[2] = top_rd;
    q_entry.px[3] = window_regs[1];
    q_entry.px[4] = window_regs[4];
    q_entry.px[5] = mid_rd;
    q_entry.px[6] = window_regs[2];
    q_entry.px[7] = window_regs[5];
    q_entry.px[8] = s1_pix;
    q_entry.zero  = s1_zero;
    q_entry.last  = s1_last;
  end

  // A stalled stage 1 keeps its pixel
  a_s1_hold: assert property (@(posedge clk) disable iff (rst)
    (s1_valid && !advance) |=> s1_valid)
    else $error("stage 1 dropped a stalled pixel");

  // Never push into a full queue
  a_q_push_ok: assert property (@(posedge clk) disable iff (rst)
    q_push |-> !q_full)
    else $error("window queue overrun");

endmodule

`default_nettype wire

@@ hw/rtl/csef_win_queue.sv @@
// ----------------------------------------------------------------------------
// csef_win_queue: short queue of 3x3 windows between front and back
// Lets the intake keep running while the filter pipeline waits for space.
// ----------------------------------------------------------------------------
`default_nettype none

module csef_win_queue import csef_pkg::*; (
  input  wire logic      clk,
  input  wire logic      rst,
  input  wire logic      push,
  input  csef_win_t      entry_in,
  output logic           full,
  input  wire logic      pop,
  output csef_win_t      entry_out,
  output logic           empty
);

  csef_win_t        slots [WQ_DEPTH];
  logic [WQ_AW-1:0] wr_ptr;
  logic [WQ_AW-1:0] rd_ptr;
  logic [WQ_AW:0]   count;
  logic             do_push;
  logic             do_pop;

  assign full    = (count == (WQ_AW+1)'(WQ_DEPTH));
  assign empty   = (count == '0);
  assign do_push = push && !full;
  assign do_pop  = pop && !empty;

  // Pointers and fill level
  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count  <= '0;
    end else begin
      if (do_push) begin
        wr_ptr <= wr_ptr + WQ_AW'(1);
      end
      if (do_pop) begin
        rd_ptr <= rd_ptr + WQ_AW'(1);
      end
      count <= count + (WQ_AW+1)'(do_push) - (WQ_AW+1)'(do_pop);
    end
  end

  // Storage
  always_ff @(posedge clk) begin
    if (do_push) begin
      slots[wr_ptr] <= entry_in;
    end
  end

  assign entry_out = slots[rd_ptr];

  // Fill level agrees with pointer distance
  a_count_ptr: assert property (@(posedge clk) disable iff (rst)
    (count != (WQ_AW+1)'(WQ_DEPTH)) |-> (count[WQ_AW-1:0] == WQ_AW'(wr_ptr - rd_ptr)))
    else $error("window queue level out of step with pointers");

endmodule

`default_nettype wire

@@ hw/rtl/csef_back.sv @@
// ----------------------------------------------------------------------------
// csef_back: compass kernel pipeline and result queue
// Per-channel arithmetic (registered kernel responses and magnitude sum, then
// scale) feeding a small output queue; issue is gated by queue credit.
// ----------------------------------------------------------------------------
`default_nettype none

module csef_back import csef_pkg::*; (
  input  wire logic               clk,
  input  wire logic               rst,
  // window queue
  input  wire logic               q_empty,
  input  csef_win_t               q_entry,
  output logic                    q_pop,
  // result channel
  output logic                    empty,
  input  wire logic               pop,
  output logic [CHAN_W-1:0]       out_red,
  output logic [CHAN_W-1:0]       out_green,
  output logic [CHAN_W-1:0]       out_blue,
  output logic                    frame_last
);

  logic                          b1_valid;
  logic signed [RESP_W-1:0]      b1_resp [3][4];
  logic                          b1_zero;
  logic                          b1_last;

  logic                          b2_valid;
  logic [7:0]                    b2_q [3];
  logic                          b2_zero;
  logic                          b2_last;

  csef_out_t                     res_in;
  csef_out_t                     slots [OUT_DEPTH];
  logic [OUT_AW-1:0]             wr_ptr;
  logic [OUT_AW-1:0]             rd_ptr;
  logic [OUT_AW:0]               out_count;
  logic [OUT_AW+1:0]             committed;
  logic                          do_pop;

  // Credit: queued plus in-flight results must fit the output queue
  assign committed = (OUT_AW+2)'(out_count) + (OUT_AW+2)'(b1_valid) +
                     (OUT_AW+2)'(b2_valid);
  assign q_pop     = !q_empty && (committed < (OUT_AW+2)'(OUT_DEPTH));
  assign do_pop    = pop && !empty;

  // Stage valids
  always_ff @(posedge clk) begin
    if (rst) begin
      b1_valid <= 1'b0;
      b2_valid <= 1'b0;
    end else begin
      b1_valid <= q_pop;
      b2_valid <= b1_valid;
    end
  end

  // Stage B1: kernel responses
  always_ff @(posedge clk) begin
    for (int ch = 0; ch < 3; ch++) begin
      for (int k = 0; k < 4; k++) begin
        b1_resp[ch][k] <= kernel_resp(get_chan(q_entry.px, ch), k);
      end
    end
    b1_zero <= q_entry.zero;
    b1_last <= q_entry.last;
  end

  // Stage B2: magnitude sum, s/8 + 15
  always_ff @(posedge clk) begin
    logic [9:0] s;
    for (int ch = 0; ch < 3; ch++) begin
      s = '0;
      for (int k = 0; k < 4; k++) begin
        s = s + 10'(resp_mag(b1_resp[ch][k]));
      end
      b2_q[ch] <= 8'(s[9:3]) + Q_OFFSET;
    end
    b2_zero <= b1_zero;
    b2_last <= b1_last;
  end

  // Final scale, border centers forced to zero
  always_comb begin
    res_in.red   = b2_zero ? '0 : scale_out(b2_q[0]);
    res_in.green = b2_zero ? '0 : scale_out(b2_q[1]);
    res_in.blue  = b2_zero ? '0 : scale_out(b2_q[2]);
    res_in.last  = b2_last;
  end

  // Output queue pointers and level
  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr    <= '0;
      rd_ptr    <= '0;
      out_count <= '0;
    end else begin
      if (b2_valid) begin
        wr_ptr <= wr_ptr + OUT_AW'(1);
      end
      if (do_pop) begin
        rd_ptr <= rd_ptr + OUT_AW'(1);
      end
      out_count <= out_count + (OUT_AW+1)'(b2_valid) - (OUT_AW+1)'(do_pop);
    end
  end

  always_ff @(posedge clk) begin
    if (b2_valid) begin
      slots[wr_ptr] <= res_in;
    end
  end

  assign empty      = (out_count == '0);
  assign out_red    = slots[rd_ptr].red;
  assign out_green  = slots[rd_ptr].green;
  assign out_blue   = slots[rd_ptr].blue;
  assign frame_last = slots[rd_ptr].last;

  // Credit accounting never overcommits the output queue
  a_credit: assert property (@(posedge clk) disable iff (rst)
    committed <= (OUT_AW+2)'(OUT_DEPTH))
    else $error("output queue overcommitted");

  // A result leaving the pipeline always finds a free slot
  a_room: assert property (@(posedge clk) disable iff (rst)
    b2_valid |-> (out_count < (OUT_AW+1)'(OUT_DEPTH)))
    else $error("result written into full output queue");

endmodule

`default_nettype wire
